@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every sampled edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pcx_pkg.sv @@
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared types and constants of the PCX run-length pixel decoder.
// ----------------------------------------------------------------------------
package pcx_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES   = 2'd2;

  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam logic [7:0] RUN_MASK = 8'h3F;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] pixel_index;
    logic       last_pixel;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic step;
    logic use_latched;
    logic set_marker;
    logic start_run;
    logic count_dec;
    logic emit_err;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
    logic run_waiting;
    logic is_marker;
    logic count_zero;
    logic end_flag;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/pcx_rle_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// pcx_rle_pixel_decoder
// Run-length decoder for 8-bit single-plane PCX image data.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) takes one encoded byte per beat.
// Output channel (out_valid/out_stall/out_data) gives one palette index per
// beat, last_pixel on the final visible pixel, or one error beat when the
// stream ends before the image is complete.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; write
// only while idle. Index 0 width, 1 height, 2 bytes per line.
// Latency: a visible literal shows on out_valid the cycle after its beat.
// Throughput: one literal or marker byte per cycle while the output is free. The
// value byte of a run holds input while the run counter steps one pixel per
// cycle when the output is free. stream_end holds input for the end check.
// Out_stall holds the output register and the sequencer; input stalls too.
// Reset (rst_n low, synchronous) clears decode state, sets the config registers to 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcx_rle_pixel_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pcx_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pcx_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  pcx_pkg::ctrl_cmd_t  cmd;
  pcx_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  pcx_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_end   (in_data.stream_end),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pcx_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ASSERT_ALWAYS(a_err_beat, !(out_valid && out_data.result_kind == pcx_pkg::KIND_ERROR) || (out_data.last_pixel && out_data.pixel_index == 8'd0), "error beat malformed")
  `ASSERT_NEXT(a_end_holds, in_valid && !in_stall && in_data.stream_end, in_stall, "input taken during end check")
  `ASSERT_ALWAYS(a_no_overrun, !(in_valid && !in_stall) || !(out_valid && out_stall), "input taken while output blocked")

endmodule

@@ rtl/pcx_datapath.sv @@
// ----------------------------------------------------------------------------
// pcx_datapath
// Config registers, decode position counters, run counter and output register.
// ----------------------------------------------------------------------------
module pcx_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcx_pkg::in_item_t            in_data,
  input  logic                         cfg_we,
  input  logic [pcx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                  cfg_data,
  input  pcx_pkg::ctrl_cmd_t           cmd,
  output pcx_pkg::dp_status_t          status,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pcx_pkg::out_item_t           out_data
);

  logic [15:0] width_r, height_r, line_r;
  logic        wait_r;
  logic [5:0]  run_len_r;
  logic [5:0]  count_r;
  logic [15:0] col_r, row_r;
  logic        done_r;
  logic [7:0]  byte_r;
  logic        end_r;
  logic        out_valid_r;
  pcx_pkg::out_item_t out_data_r;

  logic [15:0] lw, h, w, vis;
  logic [15:0] col1, row1, col2;
  logic [15:0] st_col, st_row;
  logic        st_done, st_emit, st_last;
  logic        wrap;
  logic [7:0]  step_byte;
  logic        out_free;

  assign lw  = (line_r   == 16'd0) ? 16'd1 : line_r;
  assign h   = (height_r == 16'd0) ? 16'd1 : height_r;
  assign w   = (width_r  == 16'd0) ? 16'd1 : width_r;
  assign vis = (w < lw) ? w : lw;

  assign step_byte = cmd.use_latched ? byte_r : in_data.code_byte;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    st_col  = col_r;
    st_row  = row_r;
    st_done = done_r;
    st_emit = 1'b0;
    st_last = 1'b0;
    wrap    = col_r >= lw;
    col1    = wrap ? 16'd0 : col_r;
    row1    = wrap ? row_r + 16'd1 : row_r;
    col2    = col1 + 16'd1;
    if (!done_r) begin
      if (row_r >= h) begin
        st_done = 1'b1;
      end else if (wrap && (row1 >= h)) begin
        st_col  = col1;
        st_row  = row1;
        st_done = 1'b1;
      end else begin
        st_emit = col1 < vis;
        st_last = (row1 == h - 16'd1) && (col1 == vis - 16'd1);
        if (col2 >= lw) begin
          st_col  = 16'd0;
          st_row  = row1 + 16'd1;
          st_done = (row1 + 16'd1) >= h;
        end else begin
          st_col = col2;
          st_row = row1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd1;
      height_r <= 16'd1;
      line_r   <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        pcx_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        pcx_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        pcx_pkg::CFG_LINE_BYTES:   line_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      wait_r    <= 1'b0;
      run_len_r <= 6'd0;
      count_r   <= 6'd0;
      col_r     <= 16'd0;
      row_r     <= 16'd0;
      done_r    <= 1'b0;
    end else begin
      if (cmd.step) begin
        col_r  <= st_col;
        row_r  <= st_row;
        done_r <= st_done;
      end
      if (cmd.set_marker) begin
        run_len_r <= in_data.code_byte[5:0] & pcx_pkg::RUN_MASK[5:0];
        wait_r    <= 1'b1;
      end
      if (cmd.start_run) begin
        count_r   <= run_len_r;
        run_len_r <= 6'd0;
        wait_r    <= 1'b0;
      end else if (cmd.count_dec) begin
        count_r <= count_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_r <= 1'b0;
    end else if (cmd.load_in) begin
      end_r <= in_data.stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_r <= in_data.code_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.step && st_emit) || cmd.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && st_emit) begin
      out_data_r.result_kind <= pcx_pkg::KIND_PIXEL;
      out_data_r.pixel_index <= step_byte;
      out_data_r.last_pixel  <= st_last;
    end else if (cmd.emit_err) begin
      out_data_r.result_kind <= pcx_pkg::KIND_ERROR;
      out_data_r.pixel_index <= 8'd0;
      out_data_r.last_pixel  <= 1'b1;
    end
  end

  assign status.done        = done_r;
  assign status.run_waiting = wait_r;
  assign status.is_marker   = (in_data.code_byte & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK;
  assign status.count_zero  = count_r == 6'd0;
  assign status.end_flag    = end_r;
  assign status.out_free    = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/pcx_controller.sv @@
// ----------------------------------------------------------------------------
// pcx_controller
// Sequencer: byte intake, run expansion and end-of-stream handling.
// ----------------------------------------------------------------------------
module pcx_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_end,
  output logic                in_stall,
  input  pcx_pkg::dp_status_t status,
  output pcx_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_END  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = !((state_r == S_IDLE) && status.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          if (!status.done && status.run_waiting) begin
            cmd.start_run = 1'b1;
            state_nxt     = S_RUN;
          end else begin
            if (!status.done && status.is_marker) begin
              cmd.set_marker = 1'b1;
            end else if (!status.done) begin
              cmd.step = 1'b1;
            end
            if (in_end) begin
              state_nxt = S_END;
            end
          end
        end
      end
      S_RUN: begin
        if (status.count_zero || status.done) begin
          state_nxt = status.end_flag ? S_END : S_IDLE;
        end else if (status.out_free) begin
          cmd.step        = 1'b1;
          cmd.use_latched = 1'b1;
          cmd.count_dec   = 1'b1;
        end
      end
      S_END: begin
        if (status.done) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit_err = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ tb/pcx_rle_pixel_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// pcx_rle_pixel_decoder_tb
// Self-checking bench for the PCX run-length pixel decoder.
// ----------------------------------------------------------------------------
// Encoded bytes go in one beat at a time. A line-by-line decode model inside
// the bench predicts the palette indices, last-pixel flags and short-stream
// errors for each accepted beat. Every result beat is checked against the
// oldest prediction. Directed tests cover padding, runs, clamping, zero
// registers and geometry changes mid-image. Random phases then send encoded
// images, truncated images and noise under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module pcx_rle_pixel_decoder_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_BYTES   = 130;
  localparam int MAX_GAP        = 14;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  pcx_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_stall;
  pcx_pkg::out_item_t            out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [pcx_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                   cfg_data;

  // decode model state
  logic [15:0]        img_w, img_h, line_w;
  logic               mark_pending;
  logic [5:0]         rep_count;
  int unsigned        col_pos, row_pos;
  logic               img_complete;
  pcx_pkg::out_item_t pixel_expect_q[$];

  int  fail_count = 0;
  int  sent_count = 0;
  int  quiet_cycles = 0;
  int  out_hold = 0;
  bit  in_quiet = 0;
  bit  out_quiet = 0;

  pcx_rle_pixel_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------- decode model ----------------

  function automatic void clear_decode();
    mark_pending = 1'b0;
    rep_count    = '0;
    col_pos      = 0;
    row_pos      = 0;
    img_complete = 1'b0;
  endfunction

  function automatic void add_expected(logic kind, logic [7:0] pix, logic last);
    pcx_pkg::out_item_t it;
    it.result_kind = kind;
    it.pixel_index = pix;
    it.last_pixel  = last;
    pixel_expect_q.insert(pixel_expect_q.size(), it);
  endfunction

  function automatic void place_byte(logic [7:0] b);
    int unsigned lw, h, w, vis;
    lw  = (line_w == 0) ? 1 : line_w;
    h   = (img_h == 0) ? 1 : img_h;
    w   = (img_w == 0) ? 1 : img_w;
    vis = (w < lw) ? w : lw;
    if (img_complete)
      return;
    if (row_pos >= h) begin
      img_complete = 1'b1;
      return;
    end
    if (col_pos >= lw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        img_complete = 1'b1;
        return;
      end
    end
    if (col_pos < vis)
      add_expected(pcx_pkg::KIND_PIXEL, b, (row_pos == h - 1) && (col_pos == vis - 1));
    col_pos++;
    if (col_pos >= lw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h)
        img_complete = 1'b1;
    end
  endfunction

  function automatic void predict_beat(pcx_pkg::in_item_t it);
    int i;
    if (!img_complete) begin
      if (mark_pending) begin
        mark_pending = 1'b0;
        for (i = 0; i < rep_count && !img_complete; i++)
          place_byte(it.code_byte);
        rep_count = '0;
      end else if ((it.code_byte & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK) begin
        rep_count    = it.code_byte[5:0] & pcx_pkg::RUN_MASK[5:0];
        mark_pending = 1'b1;
      end else begin
        place_byte(it.code_byte);
      end
    end
    if (it.stream_end) begin
      if (!img_complete)
        add_expected(pcx_pkg::KIND_ERROR, 8'h00, 1'b1);
      clear_decode();
    end
  endfunction

  function automatic void apply_reg(logic [pcx_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      pcx_pkg::CFG_IMAGE_WIDTH: begin
        img_w = val;
      end
      pcx_pkg::CFG_IMAGE_HEIGHT: begin
        img_h = val;
      end
      pcx_pkg::CFG_LINE_BYTES: begin
        line_w = val;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_result(pcx_pkg::out_item_t got);
    pcx_pkg::out_item_t want;
    if (pixel_expect_q.size() == 0) begin
      $error("unexpected result beat: kind %0d pixel %02h last %0d",
             got.result_kind, got.pixel_index, got.last_pixel);
      fail_count++;
      return;
    end
    want = pixel_expect_q.pop_front();
    if (got.result_kind !== want.result_kind) begin
      $error("result_kind: expected %0d, actual %0d", want.result_kind, got.result_kind);
      fail_count++;
    end
    if (got.pixel_index !== want.pixel_index) begin
      $error("pixel_index: expected %02h, actual %02h", want.pixel_index, got.pixel_index);
      fail_count++;
    end
    if (got.last_pixel !== want.last_pixel) begin
      $error("last_pixel: expected %0d, actual %0d", want.last_pixel, got.last_pixel);
      fail_count++;
    end
  endfunction

  // ---------------- monitor and watchdog ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      img_w  = 16'd1;
      img_h  = 16'd1;
      line_w = 16'd1;
      clear_decode();
      pixel_expect_q.delete();
      quiet_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        out_hold = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (cfg_valid && cfg_ready)
        apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        predict_beat(in_data);
      if ((out_valid && !out_stall) || (cfg_valid && cfg_ready) || (in_valid && !in_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold = out_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------- drivers ----------------

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{code_byte: b, stream_end: last};
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pcx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [15:0] w, input logic [15:0] h,
                              input logic [15:0] lb);
    settle();
    write_reg(pcx_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(pcx_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(pcx_pkg::CFG_LINE_BYTES, lb);
  endtask

  // ---------------- tests ----------------

  // padded rows, run into the last row, bytes after the image is done
  task automatic test_rows_and_padding();
    set_geometry(16'd2, 16'd2, 16'd3);
    send_byte(8'h00, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
  endtask

  // zero-length run, longest run past image end, marker cut by stream end
  task automatic test_run_counts();
    set_geometry(16'd3, 16'd1, 16'd3);
    send_byte(8'hC0, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hE1, 1'b1);
    set_geometry(16'd2, 16'd2, 16'd2);
    send_byte(8'hC4, 1'b1);
  endtask

  // stream ends inside the padding of the last row
  task automatic test_short_streams();
    set_geometry(16'd2, 16'd1, 16'd4);
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b0);
    send_byte(8'h07, 1'b1);
  endtask

  // width wider than the line, then all registers zero
  task automatic test_width_clamp();
    set_geometry(16'd8, 16'd2, 16'd3);
    send_byte(8'h3F, 1'b0);
    send_byte(8'hC4, 1'b0);
    send_byte(8'h9A, 1'b0);
    send_byte(8'h11, 1'b1);
    set_geometry(16'd0, 16'd0, 16'd0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // line length shrinks mid-image, then largest geometry with short stream
  task automatic test_geometry_change();
    set_geometry(16'd3, 16'd3, 16'd3);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    settle();
    write_reg(pcx_pkg::CFG_LINE_BYTES, 16'd1);
    send_byte(8'h30, 1'b1);
    set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_byte(8'hC5, 1'b0);
    send_byte(8'h7E, 1'b1);
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic send_image(input int unsigned total, input bit close, input bit cut);
    logic [7:0]  enc_q[$];
    logic [7:0]  v;
    int unsigned run;
    int          n, i;
    while (total > 0) begin
      v = 8'($urandom_range(0, 255));
      if (v >= pcx_pkg::RUN_MARK || $urandom_range(0, 2) == 0) begin
        run = $urandom_range(1, (total < 63) ? total : 63);
        if ($urandom_range(0, 7) == 0)
          run = $urandom_range(0, 63);
        enc_q.insert(enc_q.size(), pcx_pkg::RUN_MARK | run[5:0]);
        enc_q.insert(enc_q.size(), v);
        total = (run >= total) ? 0 : total - run;
      end else begin
        enc_q.insert(enc_q.size(), v);
        total--;
      end
    end
    if (!cut && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) enc_q.insert(enc_q.size(), 8'($urandom_range(0, 255)));
    n = cut ? $urandom_range(1, enc_q.size()) : enc_q.size();
    for (i = 0; i < n; i++)
      send_byte(enc_q[i], close && (i == n - 1));
  endtask

  task automatic test_random_images();
    logic [15:0] w, h, lb;
    int unsigned total;
    int          start, mode;
    start = sent_count;
    while (sent_count - start < RANDOM_BYTES) begin
      in_quiet  = ($urandom_range(0, 4) == 0);
      out_quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        w  = pick_extreme();
        h  = pick_extreme();
        lb = pick_extreme();
      end else begin
        w  = 16'($urandom_range(1, 6));
        h  = 16'($urandom_range(1, 4));
        lb = 16'($urandom_range(1, 8));
      end
      total = ((h == 0) ? 1 : h) * ((lb == 0) ? 1 : lb);
      if (total > 48)
        total = 48;
      set_geometry(w, h, lb);
      mode = $urandom_range(0, 9);
      case (mode)
        0: begin
          repeat ($urandom_range(1, 12))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        1: begin
          send_image(total, 1'b1, 1'b1);
        end
        2: begin
          send_image(total, 1'b0, 1'b1);
        end
        default: begin
          send_image(total, 1'b1, 1'b0);
        end
      endcase
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = pcx_pkg::CFG_IMAGE_WIDTH;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_rows_and_padding();
    test_run_counts();
    test_short_streams();
    test_width_clamp();
    test_geometry_change();
    test_random_images();

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pcx_pkg.sv
rtl/pcx_datapath.sv
rtl/pcx_controller.sv
rtl/pcx_rle_pixel_decoder.sv
tb/pcx_rle_pixel_decoder_tb.sv
